// ===== hw/rtl/wsi_pkg.sv =====
// ----------------------------------------------------------------------------
// wsi_pkg
// Widths and constants shared by the Wilson score interval datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wsi_pkg;

  localparam int CW   = 16;              // count field width
  localparam int FB   = 16;              // fraction bits of a bound
  localparam int SW   = CW + 1;          // s or f of one bound (one sum of two counts)
  localparam int NW   = CW + 2;          // n = s + f
  localparam int PW   = 2 * SW + 12;     // 2500 * s * f
  localparam int DW   = PW + 2 * FB;     // dividend and quotient of (p << 2F) / n
  localparam int YW   = 2 * FB + NW + 11;
  localparam int RW   = (YW + 1) / 2;    // root bits
  localparam int YPW  = 2 * RW;          // radicand padded to whole digit pairs
  localparam int AW   = SW + 12;         // a = 1250 s + 2401
  localparam int DDW  = NW + 12;         // d = 1250 n + 4802
  localparam int DVW  = RW + 6;          // 49 * root
  localparam int BW   = AW + FB;         // a << F
  localparam int NUMW = BW + 2;          // rounded numerator
  localparam int QW   = FB + 2;          // final quotient bits

  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

endpackage

`default_nettype wire

// ===== hw/rtl/wsi_bound.sv =====
// ----------------------------------------------------------------------------
// wsi_bound
// One Wilson bound, fully pipelined: product, long division, square root,
// rounding division and saturation, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_bound (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   is_upper,
  input  logic                   in_valid,
  input  logic [wsi_pkg::SW-1:0] in_s,
  input  logic [wsi_pkg::SW-1:0] in_f,
  output logic                   out_valid,
  output logic [wsi_pkg::FB:0]   out_bound
);
  import wsi_pkg::*;

  // stage 1: n, s*f, a
  logic            s1_v_r;
  logic [NW-1:0]   s1_n_r, s1_n_nxt;
  logic [2*SW-1:0] s1_sf_r, s1_sf_nxt;
  logic [AW-1:0]   s1_a_r, s1_a_nxt;

  // stage 2: p, d
  logic            s2_v_r;
  logic [PW-1:0]   s2_p_r, s2_p_nxt;
  logic [NW-1:0]   s2_n_r;
  logic [AW-1:0]   s2_a_r;
  logic [DDW-1:0]  s2_d_r, s2_d_nxt;
  logic            s2_z_r;

  // long division (p << 2F) / n, one quotient bit per stage
  logic            dv_v_r   [DW];
  logic [NW-1:0]   dv_rem_r [DW];
  logic [DW-1:0]   dv_dq_r  [DW];
  logic [NW-1:0]   dv_n_r   [DW];
  logic [AW-1:0]   dv_a_r   [DW];
  logic [DDW-1:0]  dv_d_r   [DW];
  logic            dv_z_r   [DW];
  logic            dv_v_nxt   [DW];
  logic [NW-1:0]   dv_rem_nxt [DW];
  logic [DW-1:0]   dv_dq_nxt  [DW];
  logic [NW-1:0]   dv_n_nxt   [DW];
  logic [AW-1:0]   dv_a_nxt   [DW];
  logic [DDW-1:0]  dv_d_nxt   [DW];
  logic            dv_z_nxt   [DW];

  // radicand
  logic            y_v_r;
  logic [YPW-1:0]  y_r, y_nxt;
  logic [AW-1:0]   y_a_r;
  logic [DDW-1:0]  y_d_r;

  // square root, one root bit per stage
  logic            sq_v_r    [RW];
  logic [YPW-1:0]  sq_y_r    [RW];
  logic [RW-1:0]   sq_root_r [RW];
  logic [RW:0]     sq_rem_r  [RW];
  logic [AW-1:0]   sq_a_r    [RW];
  logic [DDW-1:0]  sq_d_r    [RW];
  logic            sq_v_nxt    [RW];
  logic [YPW-1:0]  sq_y_nxt    [RW];
  logic [RW-1:0]   sq_root_nxt [RW];
  logic [RW:0]     sq_rem_nxt  [RW];
  logic [AW-1:0]   sq_a_nxt    [RW];
  logic [DDW-1:0]  sq_d_nxt    [RW];

  // deviation and base
  logic            pa_v_r;
  logic [DVW-1:0]  pa_dev_r, pa_dev_nxt;
  logic [BW-1:0]   pa_base_r, pa_base_nxt;
  logic [DDW-1:0]  pa_d_r;

  // rounded numerator
  logic            pb_v_r;
  logic [NUMW-1:0] pb_num_r, pb_num_nxt;
  logic            pb_clamp_r, pb_clamp_nxt;
  logic [DDW-1:0]  pb_d_r;

  // rounding division num / d
  logic            fd_v_r     [QW];
  logic [DDW-1:0]  fd_rem_r   [QW];
  logic [QW-1:0]   fd_q_r     [QW];
  logic [DDW-1:0]  fd_d_r     [QW];
  logic            fd_clamp_r [QW];
  logic            fd_v_nxt     [QW];
  logic [DDW-1:0]  fd_rem_nxt   [QW];
  logic [QW-1:0]   fd_q_nxt     [QW];
  logic [DDW-1:0]  fd_d_nxt     [QW];
  logic            fd_clamp_nxt [QW];

  logic            out_v_r;
  logic [FB:0]     out_r, out_nxt;

  always_comb begin
    s1_n_nxt  = NW'(in_s) + NW'(in_f);
    s1_sf_nxt = (2*SW)'(in_s) * (2*SW)'(in_f);
    s1_a_nxt  = AW'(in_s) * AW'(1250) + AW'(2401);
    s2_p_nxt  = PW'(s1_sf_r) * PW'(2500);
    s2_d_nxt  = DDW'(s1_n_r) * DDW'(1250) + DDW'(4802);
  end

  always_comb begin
    logic [NW-1:0]  rem_i;
    logic [DW-1:0]  dq_i;
    logic [NW-1:0]  n_i;
    logic [NW:0]    rem_t;
    logic           ge;
    for (int k = 0; k < DW; k++) begin
      if (k == 0) begin
        dv_v_nxt[k] = s2_v_r;
        rem_i       = '0;
        dq_i        = DW'(s2_p_r) << (2 * FB);
        n_i         = s2_n_r;
        dv_a_nxt[k] = s2_a_r;
        dv_d_nxt[k] = s2_d_r;
        dv_z_nxt[k] = s2_z_r;
      end else begin
        dv_v_nxt[k] = dv_v_r[k-1];
        rem_i       = dv_rem_r[k-1];
        dq_i        = dv_dq_r[k-1];
        n_i         = dv_n_r[k-1];
        dv_a_nxt[k] = dv_a_r[k-1];
        dv_d_nxt[k] = dv_d_r[k-1];
        dv_z_nxt[k] = dv_z_r[k-1];
      end
      rem_t         = {rem_i, dq_i[DW-1]};
      ge            = rem_t >= {1'b0, n_i};
      dv_rem_nxt[k] = NW'(ge ? rem_t - {1'b0, n_i} : rem_t);
      dv_dq_nxt[k]  = {dq_i[DW-2:0], ge};
      dv_n_nxt[k]   = n_i;
    end
  end

  // zero total drops the s*f/n term
  always_comb begin
    y_nxt = YPW'(2401) << (2 * FB);
    if (!dv_z_r[DW-1]) begin
      y_nxt = y_nxt + YPW'(dv_dq_r[DW-1]);
    end
  end

  always_comb begin
    logic [YPW-1:0] y_i;
    logic [RW-1:0]  root_i;
    logic [RW:0]    rem_i;
    logic [RW+2:0]  rem_t;
    logic [RW+2:0]  trial;
    logic           ge;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        sq_v_nxt[k] = y_v_r;
        y_i         = y_r;
        root_i      = '0;
        rem_i       = '0;
        sq_a_nxt[k] = y_a_r;
        sq_d_nxt[k] = y_d_r;
      end else begin
        sq_v_nxt[k] = sq_v_r[k-1];
        y_i         = sq_y_r[k-1];
        root_i      = sq_root_r[k-1];
        rem_i       = sq_rem_r[k-1];
        sq_a_nxt[k] = sq_a_r[k-1];
        sq_d_nxt[k] = sq_d_r[k-1];
      end
      rem_t          = {rem_i, y_i[YPW-1:YPW-2]};
      trial          = (RW+3)'({root_i, 2'b01});
      ge             = rem_t >= trial;
      sq_rem_nxt[k]  = (RW+1)'(ge ? rem_t - trial : rem_t);
      sq_root_nxt[k] = {root_i[RW-2:0], ge};
      sq_y_nxt[k]    = y_i << 2;
    end
  end

  always_comb begin
    pa_dev_nxt  = DVW'(sq_root_r[RW-1]) * DVW'(49);
    pa_base_nxt = BW'(sq_a_r[RW-1]) << FB;
  end

  always_comb begin
    pb_clamp_nxt = 1'b0;
    if (is_upper) begin
      pb_num_nxt = NUMW'(pa_base_r) + NUMW'(pa_dev_r) + NUMW'(pa_d_r >> 1);
    end else begin
      pb_clamp_nxt = pa_dev_r > pa_base_r;
      pb_num_nxt   = NUMW'(pa_base_r) - NUMW'(pa_dev_r) + NUMW'(pa_d_r >> 1);
    end
  end

  always_comb begin
    logic [DDW-1:0] rem_i;
    logic [QW-1:0]  q_i;
    logic [DDW-1:0] d_i;
    logic [DDW:0]   rem_t;
    logic           ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        fd_v_nxt[k]     = pb_v_r;
        rem_i           = DDW'(pb_num_r >> QW);
        q_i             = pb_num_r[QW-1:0];
        d_i             = pb_d_r;
        fd_clamp_nxt[k] = pb_clamp_r;
      end else begin
        fd_v_nxt[k]     = fd_v_r[k-1];
        rem_i           = fd_rem_r[k-1];
        q_i             = fd_q_r[k-1];
        d_i             = fd_d_r[k-1];
        fd_clamp_nxt[k] = fd_clamp_r[k-1];
      end
      rem_t         = {rem_i, q_i[QW-1]};
      ge            = rem_t >= {1'b0, d_i};
      fd_rem_nxt[k] = DDW'(ge ? rem_t - {1'b0, d_i} : rem_t);
      fd_q_nxt[k]   = {q_i[QW-2:0], ge};
      fd_d_nxt[k]   = d_i;
    end
  end

  always_comb begin
    if (fd_clamp_r[QW-1]) begin
      out_nxt = '0;
    end else if (fd_q_r[QW-1] > QW'(ONE)) begin
      out_nxt = ONE;
    end else begin
      out_nxt = (FB+1)'(fd_q_r[QW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      y_v_r   <= 1'b0;
      pa_v_r  <= 1'b0;
      pb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < DW; k++) dv_v_r[k] <= 1'b0;
      for (int k = 0; k < RW; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k < QW; k++) fd_v_r[k] <= 1'b0;
    end else begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      y_v_r   <= dv_v_r[DW-1];
      pa_v_r  <= sq_v_r[RW-1];
      pb_v_r  <= pa_v_r;
      out_v_r <= fd_v_r[QW-1];
      for (int k = 0; k < DW; k++) dv_v_r[k] <= dv_v_nxt[k];
      for (int k = 0; k < RW; k++) sq_v_r[k] <= sq_v_nxt[k];
      for (int k = 0; k < QW; k++) fd_v_r[k] <= fd_v_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    s1_n_r     <= s1_n_nxt;
    s1_sf_r    <= s1_sf_nxt;
    s1_a_r     <= s1_a_nxt;
    s2_p_r     <= s2_p_nxt;
    s2_n_r     <= s1_n_r;
    s2_a_r     <= s1_a_r;
    s2_d_r     <= s2_d_nxt;
    s2_z_r     <= s1_n_r == '0;
    for (int k = 0; k < DW; k++) begin
      dv_rem_r[k] <= dv_rem_nxt[k];
      dv_dq_r[k]  <= dv_dq_nxt[k];
      dv_n_r[k]   <= dv_n_nxt[k];
      dv_a_r[k]   <= dv_a_nxt[k];
      dv_d_r[k]   <= dv_d_nxt[k];
      dv_z_r[k]   <= dv_z_nxt[k];
    end
    y_r        <= y_nxt;
    y_a_r      <= dv_a_r[DW-1];
    y_d_r      <= dv_d_r[DW-1];
    for (int k = 0; k < RW; k++) begin
      sq_y_r[k]    <= sq_y_nxt[k];
      sq_root_r[k] <= sq_root_nxt[k];
      sq_rem_r[k]  <= sq_rem_nxt[k];
      sq_a_r[k]    <= sq_a_nxt[k];
      sq_d_r[k]    <= sq_d_nxt[k];
    end
    pa_dev_r   <= pa_dev_nxt;
    pa_base_r  <= pa_base_nxt;
    pa_d_r     <= sq_d_r[RW-1];
    pb_num_r   <= pb_num_nxt;
    pb_clamp_r <= pb_clamp_nxt;
    pb_d_r     <= pa_d_r;
    for (int k = 0; k < QW; k++) begin
      fd_rem_r[k]   <= fd_rem_nxt[k];
      fd_q_r[k]     <= fd_q_nxt[k];
      fd_d_r[k]     <= fd_d_nxt[k];
      fd_clamp_r[k] <= fd_clamp_nxt[k];
    end
    out_r      <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_bound = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/wilson_score_interval.sv =====
// ----------------------------------------------------------------------------
// wilson_score_interval
// 95% Wilson score interval, undecided trials counted pessimistically for the
// lower bound and optimistically for the upper bound.
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  input     in_successes, in_failures, in_unknowns         start, busy
//  result    out_lower_bound, out_upper_bound (Q1.16)       out_valid strobe
//
//  an item is taken every cycle; busy never rises
//  each result passes through the 78-stage long division, the 31-stage
//  square root and the 18-stage rounding division
//  rst_n is synchronous and clears every valid bit of the pipeline
//  the receiver has no stall, so the pipeline advances every cycle
`default_nettype none

module wilson_score_interval (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [wsi_pkg::CW-1:0] in_successes,
  input  logic [wsi_pkg::CW-1:0] in_failures,
  input  logic [wsi_pkg::CW-1:0] in_unknowns,
  output logic                   out_valid,
  output logic [wsi_pkg::FB:0]   out_lower_bound,
  output logic [wsi_pkg::FB:0]   out_upper_bound
);
  import wsi_pkg::*;

  logic          in_v_r, in_v_nxt;
  logic [SW-1:0] lo_s_r, lo_s_nxt, lo_f_r, lo_f_nxt;
  logic [SW-1:0] up_s_r, up_s_nxt, up_f_r, up_f_nxt;
  logic          lo_valid, up_valid;

  assign busy = 1'b0;

  always_comb begin
    in_v_nxt = start && !busy;
    lo_s_nxt = SW'(in_successes);
    lo_f_nxt = SW'(in_failures) + SW'(in_unknowns);
    up_s_nxt = SW'(in_successes) + SW'(in_unknowns);
    up_f_nxt = SW'(in_failures);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    lo_s_r <= lo_s_nxt;
    lo_f_r <= lo_f_nxt;
    up_s_r <= up_s_nxt;
    up_f_r <= up_f_nxt;
  end

  wsi_bound u_lower (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_upper  (1'b0),
    .in_valid  (in_v_r),
    .in_s      (lo_s_r),
    .in_f      (lo_f_r),
    .out_valid (lo_valid),
    .out_bound (out_lower_bound)
  );

  wsi_bound u_upper (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_upper  (1'b1),
    .in_valid  (in_v_r),
    .in_s      (up_s_r),
    .in_f      (up_f_r),
    .out_valid (up_valid),
    .out_bound (out_upper_bound)
  );

  // both lanes have the same depth
  assign out_valid = lo_valid & up_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/wsi_checker.sv =====
// ----------------------------------------------------------------------------
// wsi_checker
// Port-level checks on the Wilson score interval block.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [wsi_pkg::FB:0]   out_lower_bound,
  input logic [wsi_pkg::FB:0]   out_upper_bound
);
  import wsi_pkg::*;

  // the pipeline never holds items off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy)
    else $error("busy raised while an item was offered");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lower_bound <= out_upper_bound)
    else $error("lower bound above upper bound");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_upper_bound <= ONE) && (out_lower_bound < ONE))
    else $error("bound outside [0,1]");

  // reset flushes every item in flight
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind wilson_score_interval wsi_checker u_wsi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_lower_bound (out_lower_bound),
  .out_upper_bound (out_upper_bound)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams count triples into the Wilson score interval block and checks both
// bounds of every result against an integer predictor kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wsi_pkg::*;

  localparam int LATENCY   = 134;
  localparam int LIMIT     = 200000;
  localparam int N_RANDOM  = 1150;

  typedef struct packed {
    logic [CW-1:0] succ;
    logic [CW-1:0] fail;
    logic [CW-1:0] undec;
  } counts_t;

  typedef struct packed {
    logic [FB:0] lo;
    logic [FB:0] hi;
  } bounds_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] in_successes = '0;
  logic [CW-1:0] in_failures = '0;
  logic [CW-1:0] in_unknowns = '0;
  logic out_valid;
  logic [FB:0] out_lower_bound;
  logic [FB:0] out_upper_bound;

  counts_t pending_items[$];
  bounds_t expected_bounds[$];
  int errors = 0;
  int cycles = 0;
  int idle_left = 0;
  bit quiet_phase = 1'b0;

  wilson_score_interval dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_successes(in_successes), .in_failures(in_failures),
    .in_unknowns(in_unknowns), .out_valid(out_valid),
    .out_lower_bound(out_lower_bound), .out_upper_bound(out_upper_bound)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bit_val;
    root = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > v) bit_val >>= 2;
    while (bit_val != 0) begin
      if (v >= root + bit_val) begin
        v -= root + bit_val;
        root = (root >> 1) + bit_val;
      end else begin
        root >>= 1;
      end
      bit_val >>= 2;
    end
    return root;
  endfunction

  function automatic logic [FB:0] wilson_limit(longint unsigned s, longint unsigned f,
                                               bit upper);
    longint unsigned n, y, p, q, r, root, a, d, base, dev, num, res;
    n = s + f;
    y = 64'd2401 << (2 * FB);
    // empty sample: the s*f/n term drops out
    if (n != 0) begin
      p = 64'd2500 * s * f;
      q = p / n;
      r = p % n;
      y += q << (2 * FB);
      y += (r << (2 * FB)) / n;
    end
    root = int_sqrt(y);
    a = 64'd1250 * s + 2401;
    d = 64'd1250 * n + 4802;
    base = a << FB;
    dev = 64'd49 * root;
    if (upper) begin
      num = base + dev;
    end else begin
      if (dev > base) return '0;
      num = base - dev;
    end
    res = (num + d / 2) / d;
    if (res > (64'd1 << FB)) res = 64'd1 << FB;
    return res[FB:0];
  endfunction

  function automatic bounds_t predict_interval(counts_t c);
    bounds_t b;
    b.lo = wilson_limit(c.succ, longint'(c.fail) + c.undec, 1'b0);
    b.hi = wilson_limit(longint'(c.succ) + c.undec, c.fail, 1'b1);
    return b;
  endfunction

  function automatic logic [CW-1:0] rand_count();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 3));
      1: return CW'($urandom_range(0, 255));
      2: return CW'({CW{1'b1}} - $urandom_range(0, 3));
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic add_item(logic [CW-1:0] s, logic [CW-1:0] f, logic [CW-1:0] u);
    counts_t c;
    c.succ = s;
    c.fail = f;
    c.undec = u;
    pending_items.push_back(c);
  endtask

  initial begin
    logic [CW-1:0] mx;
    mx = {CW{1'b1}};
    add_item(0, 0, 0);
    add_item(0, 0, 1);
    add_item(0, 0, mx);
    add_item(1, 0, 0);
    add_item(0, 1, 0);
    add_item(mx, 0, 0);
    add_item(0, mx, 0);
    add_item(mx, mx, 0);
    add_item(mx, mx, mx);
    add_item(mx, 0, mx);
    add_item(0, mx, mx);
    add_item(1, 1, 0);
    add_item(1, 1, 1);
    add_item(50, 50, 0);
    add_item(16'h5555, 16'haaaa, 16'h5555);
    add_item(16'haaaa, 16'h5555, 16'haaaa);
    add_item(1, mx, 0);
    add_item(mx, 1, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      // plain interval often, so unknowns = 0 gets good coverage
      add_item(rand_count(), rand_count(),
               ($urandom_range(0, 3) == 0) ? CW'(0) : rand_count());
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the current item
    end else begin
      if (start) void'(pending_items.pop_front());
      quiet_phase <= pending_items.size() < 150;
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 2);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_successes <= pending_items[0].succ;
        in_failures <= pending_items[0].fail;
        in_unknowns <= pending_items[0].undec;
        expected_bounds.push_back(predict_interval(pending_items[0]));
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bounds_t exp_b;
    if (rst_n && out_valid) begin
      if (expected_bounds.size() == 0) begin
        $display("%0t: unexpected result lower=%0d upper=%0d", $time,
                 out_lower_bound, out_upper_bound);
        errors++;
      end else begin
        exp_b = expected_bounds.pop_front();
        if (out_lower_bound !== exp_b.lo) begin
          $display("%0t: lower_bound expected %0d actual %0d", $time, exp_b.lo,
                   out_lower_bound);
          errors++;
        end
        if (out_upper_bound !== exp_b.hi) begin
          $display("%0t: upper_bound expected %0d actual %0d", $time, exp_b.hi,
                   out_upper_bound);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pending_items.size() == 0 && !start);
    wait (expected_bounds.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_bounds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
